// ===== rtl/cswc_pkg.sv =====
package cswc_pkg;

    localparam int VALUE_WIDTH_DEF = 31;
    localparam int WAY_COUNT_WIDTH = 11;
    localparam logic [WAY_COUNT_WIDTH-1:0] WAY_COUNT_MAX = '1;

    typedef struct packed {
        logic done;
        logic zero;
    } rem_status_t;

endpackage

// ===== rtl/cswc_rem_unit.sv =====
module cswc_rem_unit #(
    parameter int VALUE_WIDTH = cswc_pkg::VALUE_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [VALUE_WIDTH-1:0]   dividend,
    input  logic [VALUE_WIDTH-1:0]   divisor,
    output cswc_pkg::rem_status_t    status
);
    import cswc_pkg::*;

    localparam int CNT_WIDTH = $clog2(VALUE_WIDTH + 1);
    localparam logic [CNT_WIDTH-1:0] CNT_LOAD = CNT_WIDTH'(VALUE_WIDTH);
    localparam logic [CNT_WIDTH-1:0] CNT_ONE  = CNT_WIDTH'(1);

    logic [VALUE_WIDTH:0]   rem_reg, rem_next;
    logic [VALUE_WIDTH-1:0] dvd_reg, dvd_next;
    logic [VALUE_WIDTH-1:0] dsr_reg, dsr_next;
    logic [CNT_WIDTH-1:0]   cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;

    logic [VALUE_WIDTH:0]   shifted;
    logic [VALUE_WIDTH+1:0] diff;

    // one restoring step per cycle
    assign shifted = {rem_reg[VALUE_WIDTH-1:0], dvd_reg[VALUE_WIDTH-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dsr_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = CNT_LOAD;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = diff[VALUE_WIDTH+1] ? shifted : diff[VALUE_WIDTH:0];
            dvd_next = {dvd_reg[VALUE_WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_ONE;
            if (cnt_reg == CNT_ONE)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
    end

    assign status.done = done_reg;
    assign status.zero = (rem_reg == '0);

endmodule

// ===== rtl/consecutive_sum_way_counter.sv =====
// The number of run lengths tried is about sqrt(2 * value).
// Each run length costs one bound check plus VALUE_WIDTH remainder steps of the shared divider.
// Throughput: one transaction at a time; s_tready is high only between items.
// Reset: rst_n asynchronous, active low; clears the sequencer and the output valid.
module consecutive_sum_way_counter #(
    parameter int VALUE_WIDTH = cswc_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0]       s_tdata,  // [VALUE_WIDTH-1:0] value
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [((cswc_pkg::WAY_COUNT_WIDTH+7)/8)*8-1:0] m_tdata  // [10:0] way_count
);
    import cswc_pkg::*;

    localparam int OUT_TDATA_WIDTH = ((WAY_COUNT_WIDTH + 7) / 8) * 8;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_WAIT  = 3'd2;
    localparam logic [2:0] ST_DONE  = 3'd3;

    logic [2:0]                 state_reg, state_next;
    logic [VALUE_WIDTH-1:0]     value_reg, value_next;
    logic [VALUE_WIDTH:0]       tri_reg, tri_next;
    logic [VALUE_WIDTH-1:0]     d_reg, d_next;
    logic [WAY_COUNT_WIDTH-1:0] hits_reg, hits_next;
    logic [WAY_COUNT_WIDTH-1:0] out_reg, out_next;
    logic                       m_tvalid_reg, m_tvalid_next;

    logic                       below;
    logic                       rem_start;
    logic [VALUE_WIDTH-1:0]     dividend;
    rem_status_t                rem_status;

    assign below     = tri_reg < {1'b0, value_reg};
    assign dividend  = value_reg - tri_reg[VALUE_WIDTH-1:0];
    assign rem_start = (state_reg == ST_CHECK) && below;

    cswc_rem_unit #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (dividend),
        .divisor  (d_reg),
        .status   (rem_status)
    );

    always_comb
    begin
        state_next    = state_reg;
        value_next    = value_reg;
        tri_next      = tri_reg;
        d_next        = d_reg;
        hits_next     = hits_reg;
        out_next      = out_reg;
        m_tvalid_next = m_tvalid_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    value_next = s_tdata[VALUE_WIDTH-1:0];
                    tri_next   = '0;
                    d_next     = VALUE_WIDTH'(1);
                    hits_next  = '0;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = below ? ST_WAIT : ST_DONE;
            end
            ST_WAIT:
            begin
                if (rem_status.done)
                begin
                    if (rem_status.zero && (hits_reg != WAY_COUNT_MAX))
                    begin
                        hits_next = hits_reg + WAY_COUNT_WIDTH'(1);
                    end
                    tri_next   = tri_reg + {1'b0, d_reg};
                    d_next     = d_reg + VALUE_WIDTH'(1);
                    state_next = ST_CHECK;
                end
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_next      = hits_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        tri_reg   <= tri_next;
        d_reg     <= d_next;
        hits_reg  <= hits_next;
        out_reg   <= out_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_TDATA_WIDTH - WAY_COUNT_WIDTH){1'b0}}, out_reg};

endmodule
